[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/arc4_pkg.sv]
// ----------------------------------------------------------------------------
// arc4_pkg
// Types, constants and the microprogram of the stream cipher engine.
// ----------------------------------------------------------------------------
`default_nettype none

package arc4_pkg;

    localparam int PERM_DEPTH    = 256;
    localparam int IDX_W         = 8;
    localparam int KEY_CHUNK_MAX = 256;
    localparam int LEN_W         = 9;
    localparam int BIT_W         = 3;
    localparam int UPC_W         = 5;

    typedef logic [IDX_W-1:0] byte_t;
    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        CMD_RESET     = 2'd0,
        CMD_KEY_WRITE = 2'd1,
        CMD_KEY_PASS  = 2'd2,
        CMD_CRYPT     = 2'd3
    } cmd_t;

    // Permutation read address select.
    typedef enum logic [2:0] {
        RD_NONE,
        RD_I,
        RD_J,
        RD_K,
        RD_TU
    } rd_sel_t;

    // Permutation write select: address and data.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_K_T,
        WR_J_T,
        WR_I_U
    } wr_sel_t;

    // Jump conditions. A taken jump loads the target, otherwise the
    // step counter advances by one.
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_LEN_ZERO,
        JC_DIV_MORE,
        JC_I_MORE
    } jc_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    ld_t;
        logic    ld_u;
        logic    ld_x;
        logic    inc_i;
        logic    add_j;
        logic    add_k;
        logic    clr_perm;
        logic    wr_key;
        logic    div_init;
        logic    div_step;
        logic    step_kidx;
        logic    fin;
        jc_t     jump;
        upc_t    target;
    } ctrl_word_t;

    typedef struct packed {
        logic item_accept;
        cmd_t cmd;
        logic len_zero;
        logic div_more;
        logic i_more;
        logic out_free;
    } seq_stat_t;

    localparam ctrl_word_t CW_NOP = '{
        rd_sel:    RD_NONE,
        wr_sel:    WR_NONE,
        ld_t:      1'b0,
        ld_u:      1'b0,
        ld_x:      1'b0,
        inc_i:     1'b0,
        add_j:     1'b0,
        add_k:     1'b0,
        clr_perm:  1'b0,
        wr_key:    1'b0,
        div_init:  1'b0,
        div_step:  1'b0,
        step_kidx: 1'b0,
        fin:       1'b0,
        jump:      JC_NEXT,
        target:    '0
    };

    // Microprogram addresses.
    localparam upc_t U_RST = 5'd0;
    localparam upc_t U_KWR = 5'd1;
    localparam upc_t U_KP0 = 5'd2;
    localparam upc_t U_KP1 = 5'd3;
    localparam upc_t U_KP2 = 5'd4;
    localparam upc_t U_KP3 = 5'd5;
    localparam upc_t U_KP4 = 5'd6;
    localparam upc_t U_KP5 = 5'd7;
    localparam upc_t U_KP6 = 5'd8;
    localparam upc_t U_FIN = 5'd9;
    localparam upc_t U_CR0 = 5'd10;
    localparam upc_t U_CR1 = 5'd11;
    localparam upc_t U_CR2 = 5'd12;
    localparam upc_t U_CR3 = 5'd13;
    localparam upc_t U_CR4 = 5'd14;
    localparam upc_t U_CR5 = 5'd15;
    localparam upc_t U_CR6 = 5'd16;
    localparam upc_t U_CR7 = 5'd17;

    function automatic upc_t entry_point(input cmd_t cmd);
        upc_t a;
        unique case (cmd)
            CMD_RESET:     a = U_RST;
            CMD_KEY_WRITE: a = U_KWR;
            CMD_KEY_PASS:  a = U_KP0;
            CMD_CRYPT:     a = U_CR0;
            default:       a = U_FIN;
        endcase
        return a;
    endfunction

    function automatic ctrl_word_t micro_rom(input upc_t a);
        ctrl_word_t cw;
        cw = CW_NOP;
        unique case (a)
            U_RST:
            begin
                cw.clr_perm = 1'b1;
                cw.jump     = JC_ALWAYS;
                cw.target   = U_FIN;
            end
            U_KWR:
            begin
                cw.wr_key = 1'b1;
                cw.jump   = JC_ALWAYS;
                cw.target = U_FIN;
            end
            U_KP0:
            begin
                cw.div_init = 1'b1;
                cw.jump     = JC_LEN_ZERO;
                cw.target   = U_FIN;
            end
            U_KP1:
            begin
                cw.div_step = 1'b1;
                cw.jump     = JC_DIV_MORE;
                cw.target   = U_KP1;
            end
            U_KP2:
            begin
                cw.rd_sel = RD_I;
            end
            U_KP3:
            begin
                cw.ld_t  = 1'b1;
                cw.add_k = 1'b1;
            end
            U_KP4:
            begin
                cw.rd_sel = RD_K;
            end
            U_KP5:
            begin
                cw.ld_u   = 1'b1;
                cw.wr_sel = WR_K_T;
            end
            U_KP6:
            begin
                cw.wr_sel    = WR_I_U;
                cw.inc_i     = 1'b1;
                cw.step_kidx = 1'b1;
                cw.jump      = JC_I_MORE;
                cw.target    = U_KP2;
            end
            U_FIN:
            begin
                cw.fin = 1'b1;
            end
            U_CR0:
            begin
                cw.inc_i = 1'b1;
            end
            U_CR1:
            begin
                cw.rd_sel = RD_I;
            end
            U_CR2:
            begin
                cw.ld_t  = 1'b1;
                cw.add_j = 1'b1;
            end
            U_CR3:
            begin
                cw.rd_sel = RD_J;
            end
            U_CR4:
            begin
                cw.ld_u   = 1'b1;
                cw.wr_sel = WR_J_T;
            end
            U_CR5:
            begin
                cw.wr_sel = WR_I_U;
            end
            U_CR6:
            begin
                cw.rd_sel = RD_TU;
            end
            U_CR7:
            begin
                cw.ld_x   = 1'b1;
                cw.jump   = JC_ALWAYS;
                cw.target = U_FIN;
            end
            default:
            begin
                cw = CW_NOP;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

[sv/arc4_keyed_stream_cipher.sv]
// ----------------------------------------------------------------------------
// arc4_keyed_stream_cipher
// Byte-wide RC4 engine run by a microprogram over one permutation memory.
// ----------------------------------------------------------------------------
// Usage. Each input word carries a command (reset permutation, write key
// byte, key schedule pass, crypt byte) with its data byte, key position
// and chunk length. It is taken when item_valid is high and item_stall is
// low. Every input word yields exactly one result word on the result
// channel, taken when result_valid is high and result_stall is low;
// out_byte carries data XOR keystream for a crypt word and zero otherwise.
// The engine works on one word at a time and holds item_stall high while
// busy; it takes the next word in the cycle after loading a result. A key
// pass runs n swap steps (n = 256 - i, or 256 when i is 0); a zero chunk
// length skips the pass. The step sequence is set by the single read port
// of the permutation memory: each swap step needs two dependent reads and
// two writes, and a crypt adds the final keystream read. A key pass first
// finds i mod length with an 8-step restoring remainder. The result
// register frees the engine to accept the next word while a result waits;
// if that result is still stalled when the next one is done, the engine
// waits in its final step.
// Reset restores the identity permutation at once (valid bits per entry)
// and clears i, j and k; the key buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module arc4_keyed_stream_cipher (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] key_position,
    input  wire logic [8:0] chunk_length,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [7:0]      out_byte,
    output logic            out_is_data
);

    arc4_pkg::ctrl_word_t cw;
    arc4_pkg::seq_stat_t  stat;
    logic                 busy;
    logic                 item_accept;
    logic                 out_free;

    // Latched input word.
    arc4_pkg::cmd_t                 cmd_reg;
    arc4_pkg::byte_t                data_reg;
    arc4_pkg::byte_t                pos_reg;
    logic [arc4_pkg::LEN_W-1:0]     len_reg;
    logic [arc4_pkg::LEN_W-1:0]     len_next;

    // Cipher state and working registers.
    arc4_pkg::byte_t                i_reg;
    arc4_pkg::byte_t                j_reg;
    arc4_pkg::byte_t                k_reg;
    arc4_pkg::byte_t                t_reg;
    arc4_pkg::byte_t                u_reg;
    arc4_pkg::byte_t                x_reg;
    arc4_pkg::byte_t                kidx_reg;
    arc4_pkg::byte_t                kidx_next;
    logic [arc4_pkg::BIT_W-1:0]     bit_reg;
    logic [arc4_pkg::LEN_W-1:0]     kidx_ext;
    logic [arc4_pkg::LEN_W-1:0]     shifted;

    // Permutation memory and per-entry valid bits.
    logic [arc4_pkg::PERM_DEPTH-1:0] vld_reg;
    arc4_pkg::byte_t                 rd_addr_reg;
    arc4_pkg::byte_t                 perm_raddr;
    arc4_pkg::byte_t                 perm_waddr;
    arc4_pkg::byte_t                 perm_wdata;
    arc4_pkg::byte_t                 perm_q;
    arc4_pkg::byte_t                 perm_rd;
    logic                            perm_re;
    logic                            perm_we;
    arc4_pkg::byte_t                 key_rd;

    // Result register.
    logic            result_valid_reg;
    arc4_pkg::byte_t out_byte_reg;
    logic            out_is_data_reg;

    assign item_stall  = busy;
    assign item_accept = item_valid && !busy;
    assign out_free    = !result_valid_reg || !result_stall;

    always_comb
    begin
        stat.item_accept = item_accept;
        stat.cmd         = arc4_pkg::cmd_t'(command);
        stat.len_zero    = (len_reg == '0);
        stat.div_more    = (bit_reg != '0);
        stat.i_more      = (i_reg != '1);
        stat.out_free    = out_free;
    end

    arc4_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cw    (cw),
        .busy  (busy)
    );

    // Chunk lengths above the buffer size use the whole buffer.
    always_comb
    begin
        if (chunk_length > arc4_pkg::LEN_W'(arc4_pkg::KEY_CHUNK_MAX))
        begin
            len_next = arc4_pkg::LEN_W'(arc4_pkg::KEY_CHUNK_MAX);
        end
        else
        begin
            len_next = chunk_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            cmd_reg  <= arc4_pkg::cmd_t'(command);
            data_reg <= data_byte;
            pos_reg  <= key_position;
            len_reg  <= len_next;
        end
    end

    // Permutation port selection.
    always_comb
    begin
        case (cw.rd_sel)
            arc4_pkg::RD_I:  perm_raddr = i_reg;
            arc4_pkg::RD_J:  perm_raddr = j_reg;
            arc4_pkg::RD_K:  perm_raddr = k_reg;
            arc4_pkg::RD_TU: perm_raddr = t_reg + u_reg;
            default:         perm_raddr = i_reg;
        endcase
        perm_re = (cw.rd_sel != arc4_pkg::RD_NONE);
    end

    always_comb
    begin
        case (cw.wr_sel)
            arc4_pkg::WR_K_T:
            begin
                perm_waddr = k_reg;
                perm_wdata = t_reg;
            end
            arc4_pkg::WR_J_T:
            begin
                perm_waddr = j_reg;
                perm_wdata = t_reg;
            end
            default:
            begin
                perm_waddr = i_reg;
                perm_wdata = u_reg;
            end
        endcase
        perm_we = (cw.wr_sel != arc4_pkg::WR_NONE);
    end

    arc4_ram #(
        .WIDTH (arc4_pkg::IDX_W),
        .DEPTH (arc4_pkg::PERM_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .re    (perm_re),
        .raddr (perm_raddr),
        .rdata (perm_q)
    );

    arc4_ram #(
        .WIDTH (arc4_pkg::IDX_W),
        .DEPTH (arc4_pkg::KEY_CHUNK_MAX)
    ) u_key_ram (
        .clk   (clk),
        .we    (cw.wr_key),
        .waddr (pos_reg),
        .wdata (data_reg),
        .re    (1'b1),
        .raddr (kidx_reg),
        .rdata (key_rd)
    );

    // An entry never written since the last reset reads as its own index.
    assign perm_rd = vld_reg[rd_addr_reg] ? perm_q : rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (perm_re)
        begin
            rd_addr_reg <= perm_raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cw.clr_perm)
        begin
            vld_reg <= '0;
        end
        else if (perm_we)
        begin
            vld_reg[perm_waddr] <= 1'b1;
        end
    end

    // Indices i, j and k.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else if (cw.clr_perm)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            if (cw.inc_i)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cw.add_j)
            begin
                j_reg <= j_reg + perm_rd;
            end
            if (cw.add_k)
            begin
                k_reg <= k_reg + perm_rd + key_rd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.ld_t)
        begin
            t_reg <= perm_rd;
        end
        if (cw.ld_u)
        begin
            u_reg <= perm_rd;
        end
        if (cw.ld_x)
        begin
            x_reg <= data_reg ^ perm_rd;
        end
    end

    // Key index: a restoring remainder of i by the chunk length, one bit of
    // i per step, then a counter that wraps at the chunk length.
    assign kidx_ext = {1'b0, kidx_reg};
    assign shifted  = {kidx_reg, i_reg[bit_reg]};

    always_comb
    begin
        kidx_next = kidx_reg;
        if (cw.div_init)
        begin
            kidx_next = '0;
        end
        else if (cw.div_step)
        begin
            if (shifted >= len_reg)
            begin
                kidx_next = arc4_pkg::IDX_W'(shifted - len_reg);
            end
            else
            begin
                kidx_next = shifted[arc4_pkg::IDX_W-1:0];
            end
        end
        else if (cw.step_kidx)
        begin
            if (kidx_ext + 1'b1 == len_reg)
            begin
                kidx_next = '0;
            end
            else
            begin
                kidx_next = kidx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kidx_reg <= kidx_next;
        if (cw.div_init)
        begin
            bit_reg <= arc4_pkg::BIT_W'(arc4_pkg::IDX_W - 1);
        end
        else if (cw.div_step)
        begin
            bit_reg <= bit_reg - 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cw.fin && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.fin && out_free)
        begin
            if (cmd_reg == arc4_pkg::CMD_CRYPT)
            begin
                out_byte_reg    <= x_reg;
                out_is_data_reg <= 1'b1;
            end
            else
            begin
                out_byte_reg    <= '0;
                out_is_data_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_is_data  = out_is_data_reg;

    `ASSERT_SAME(a_wr_not_clr, perm_we, !cw.clr_perm, "permutation write during clear")
    `ASSERT_SAME(a_kidx_range, cw.add_k, kidx_ext < len_reg, "key index beyond chunk length")
    `ASSERT_NEXT(a_accept_busy, item_accept, item_stall, "engine idle after accepting a word")
    `ASSERT_SAME(a_zero_ctrl, result_valid && !out_is_data, out_byte == '0, "control byte nonzero")

endmodule

`default_nettype wire

[sv/arc4_ram.sv]
// ----------------------------------------------------------------------------
// arc4_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module arc4_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/arc4_useq.sv]
// ----------------------------------------------------------------------------
// arc4_useq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module arc4_useq (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire arc4_pkg::seq_stat_t    stat,
    output arc4_pkg::ctrl_word_t        cw,
    output logic                        busy
);

    logic             busy_reg;
    logic             busy_next;
    arc4_pkg::upc_t   upc_reg;
    arc4_pkg::upc_t   upc_next;
    logic             taken;

    always_comb
    begin
        cw = busy_reg ? arc4_pkg::micro_rom(upc_reg) : arc4_pkg::CW_NOP;
    end

    always_comb
    begin
        unique case (cw.jump)
            arc4_pkg::JC_NEXT:     taken = 1'b0;
            arc4_pkg::JC_ALWAYS:   taken = 1'b1;
            arc4_pkg::JC_LEN_ZERO: taken = stat.len_zero;
            arc4_pkg::JC_DIV_MORE: taken = stat.div_more;
            arc4_pkg::JC_I_MORE:   taken = stat.i_more;
            default:               taken = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (!busy_reg)
        begin
            if (stat.item_accept)
            begin
                busy_next = 1'b1;
                upc_next  = arc4_pkg::entry_point(stat.cmd);
            end
        end
        else if (cw.fin)
        begin
            // The final step holds until the result register has room.
            if (stat.out_free)
            begin
                busy_next = 1'b0;
            end
        end
        else if (taken)
        begin
            upc_next = cw.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= arc4_pkg::U_FIN;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire
